// ===== sv/nws_pkg.sv =====
`default_nettype none

package nws_pkg;

  // Vector and field geometry.
  localparam int NUM_SYNAPSES = 8;
  localparam int POS_W        = 3;
  localparam int DATA_W       = 16;
  localparam int ACC_W        = 40;
  localparam int MAC_W        = 2 * DATA_W;
  localparam int CFG_IDX_W    = 4;

  // Shared multiplier: unsigned 32 x 32 with a 64-bit registered product.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Shared serial divider: one quotient bit per cycle.
  localparam int DIV_W = 49;
  localparam int QUO_W = 32;
  localparam int CNT_W = 6;

  // Activation constants.
  localparam int TAYLOR_TERMS = 12;
  localparam int K_W          = 4;
  localparam int SQ_W         = 2;
  localparam int SAT_BIT      = 27;   // |sum| >= 8.0 in Q.24
  localparam int Z_W          = 31;
  localparam int E_ACC_W      = 34;
  localparam int TERM_STEPS   = 32;
  localparam int FINAL_STEPS  = 17;
  localparam logic [MUL_W-1:0]  Q31_ONE = 32'h8000_0000;
  localparam logic [PROD_W-1:0] Q31_HALF = 64'h0000_0000_4000_0000;
  localparam logic [DATA_W-1:0] MAG_MAX = 16'h7fff;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_CHECK,
    S_TMUL,
    S_TWAIT,
    S_TDIV,
    S_CLAMP,
    S_SQMUL,
    S_SQWAIT,
    S_FSTART,
    S_FDIV,
    S_DONE
  } state_t;

  // Request to the serial divider; divisor is already aligned to the top
  // quotient bit.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/nws_mul.sv =====
`default_nettype none

module nws_mul
  import nws_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] product
);

  // Registered unsigned product, available in the cycle after the operands.
  always_ff @(posedge clk) begin
    product <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// ===== sv/nws_div.sv =====
`default_nettype none

module nws_div
  import nws_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             fits;

  assign fits = (rem >= dsh);

  // Step counter; the divider runs for the requested number of quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= req.steps;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Restoring compare and subtract, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsh <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== sv/neuron_weighted_sum_tanh.sv =====
// A word that does not end a vector is accepted and then accumulated.
// A word that ends a vector runs the activation before the result word is
// shown: 12 series terms on the shared multiplier and the one-bit-per-cycle
// divider, 4 squarings and a 17-step final divide.
// A saturated sum (|sum| >= 8.0) skips the series and goes straight to the result.
// Reset (rst, synchronous) clears weights, sum, position and the output valid.
`default_nettype none

module neuron_weighted_sum_tanh
  import nws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration writes.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  // Input stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [DATA_W-1:0]    s_axis_tdata,   // [15:0] input_value
  input  wire logic                 s_axis_tlast,   // last_input
  // Output stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [DATA_W-1:0]    m_axis_tdata    // [15:0] neuron_output
);

  state_t state, state_next;

  logic signed [DATA_W-1:0] weight [NUM_SYNAPSES];
  logic signed [ACC_W-1:0]  sum;
  logic [POS_W-1:0]         pos;
  logic signed [MAC_W-1:0]  mac_prod;
  logic                     vec_end;
  logic                     neg;
  logic [Z_W-1:0]           z;
  logic [MUL_W-1:0]         term;
  logic signed [E_ACC_W-1:0] acc;
  logic [MUL_W-1:0]         e;
  logic [K_W-1:0]           k;
  logic [SQ_W-1:0]          sq;
  logic [DATA_W-1:0]        mag;
  logic [DATA_W-1:0]        out_data;
  logic                     out_valid;

  logic [ACC_W-1:0]  abs_sum;
  logic              sat;
  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] sq_round;
  logic [MUL_W:0]    den;
  logic [MUL_W-1:0]  num_diff;
  logic [MUL_W-1:0]  e_clamp;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  nws_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  nws_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Shared helper values.
  assign abs_sum  = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
  assign sat      = (abs_sum[ACC_W-1:SAT_BIT] != '0);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign sq_round = product + Q31_HALF;
  assign den      = {1'b0, Q31_ONE} + {1'b0, e};
  assign num_diff = Q31_ONE - e;

  // Series sum clamped to 0..1.0.
  always_comb begin
    if (acc < 0) begin
      e_clamp = '0;
    end else if (acc > $signed(E_ACC_W'(Q31_ONE))) begin
      e_clamp = Q31_ONE;
    end else begin
      e_clamp = acc[MUL_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_fire) state_next = S_MAC;
      S_MAC:    state_next = vec_end ? S_CHECK : S_IDLE;
      S_CHECK:  state_next = sat ? S_DONE : S_TMUL;
      S_TMUL:   state_next = S_TWAIT;
      S_TWAIT:  state_next = S_TDIV;
      S_TDIV: begin
        if (!div_rsp.busy) begin
          state_next = (k == K_W'(TAYLOR_TERMS)) ? S_CLAMP : S_TMUL;
        end
      end
      S_CLAMP:  state_next = S_SQMUL;
      S_SQMUL:  state_next = S_SQWAIT;
      S_SQWAIT: state_next = (sq == '1) ? S_FSTART : S_SQMUL;
      S_FSTART: state_next = S_FDIV;
      S_FDIV:   if (!div_rsp.busy) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and divider requests.
  always_comb begin
    s_axis_tready    = 1'b0;
    out_load         = 1'b0;
    mul_a            = term;
    mul_b            = MUL_W'(z);
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(product[2*MUL_W-2:MUL_W-1]);
    div_req.divisor  = DIV_W'(k) << (TERM_STEPS - 1);
    div_req.steps    = CNT_W'(TERM_STEPS);
    case (state)
      S_IDLE:  s_axis_tready = 1'b1;
      S_TWAIT: div_req.start = 1'b1;
      S_SQMUL: begin
        mul_a = e;
        mul_b = e;
      end
      S_FSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = (DIV_W'(num_diff) << (DATA_W - 1)) + DIV_W'(den >> 1);
        div_req.divisor  = DIV_W'(den) << (FINAL_STEPS - 1);
        div_req.steps    = CNT_W'(FINAL_STEPS);
      end
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Weight registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SYNAPSES; i++) begin
        weight[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_SYNAPSES))) begin
      weight[cfg_index[POS_W-1:0]] <= cfg_data;
    end
  end

  // Accumulator and synapse position.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      pos <= '0;
    end else if (state == S_MAC) begin
      sum <= sum + ACC_W'(mac_prod);
      if (!vec_end) begin
        pos <= pos + POS_W'(1);
      end
    end else if (out_load) begin
      sum <= '0;
      pos <= '0;
    end
  end

  // Product of the accepted word and the weight at the current position.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mac_prod <= weight[pos] * $signed(s_axis_tdata);
      vec_end  <= s_axis_tlast || (pos == POS_W'(NUM_SYNAPSES - 1));
    end
  end

  // Activation datapath: series for exp(-z), squarings, final divide.
  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        neg  <= sum[ACC_W-1];
        mag  <= MAG_MAX;
        z    <= {abs_sum[SAT_BIT-1:0], 4'b0000};
        term <= Q31_ONE;
        acc  <= E_ACC_W'(Q31_ONE);
        k    <= K_W'(1);
      end
      S_TDIV: begin
        if (!div_rsp.busy) begin
          term <= div_rsp.quotient;
          if (k[0]) begin
            acc <= acc - $signed(E_ACC_W'(div_rsp.quotient));
          end else begin
            acc <= acc + $signed(E_ACC_W'(div_rsp.quotient));
          end
          k <= k + K_W'(1);
        end
      end
      S_CLAMP: begin
        e  <= e_clamp;
        sq <= '0;
      end
      S_SQWAIT: begin
        e  <= sq_round[2*MUL_W-2:MUL_W-1];
        sq <= sq + SQ_W'(1);
      end
      S_FDIV: begin
        if (div_rsp.quotient > QUO_W'(MAG_MAX)) begin
          mag <= MAG_MAX;
        end else begin
          mag <= div_rsp.quotient[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register; a finished word waits here for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= neg ? DATA_W'(-mag) : mag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // A new result word only comes out of the final state.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result word appeared outside the final state");

  // Saturation keeps the result inside -32767..32767.
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata != 16'h8000)
    else $error("result word holds the most negative code");

  // The shared divider is never restarted while it is still working.
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== tb/sv/tb_neuron_weighted_sum_tanh.sv =====
`default_nettype none

module tb_neuron_weighted_sum_tanh;
  import nws_pkg::*;

  // Run shape.
  localparam int RESET_ROWS      = 3;
  localparam int DIRECTED_COUNT  = 25;
  localparam int WEIGHT_SETTINGS = 8;
  localparam int WORDS_PER_SET   = 190;
  localparam int SETTLE_CYCLES   = 600;
  localparam int IDLE_LIMIT      = 20000;
  localparam int PRINT_LIMIT     = 50;
  localparam int SMALL_SPAN      = 'h0c00;
  localparam int FIRST_SPARE_IDX = NUM_SYNAPSES;

  // Activation arithmetic, all in 64-bit unsigned.
  localparam logic [63:0] ONE_Q31   = 64'd1 << 31;
  localparam logic [63:0] SAT_LEVEL = 64'd8 << 24;

  // One row of the directed table; result is used only where typed is set.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] result;
  } stim_row_t;

  // The first rows run with the weights at reset (all zero, so tanh is 0).
  // The rest run with the extreme weights below.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{16'h7fff, 1'b1, 1'b1, 16'h0000},
    '{16'h8000, 1'b0, 1'b0, 16'h0000},
    '{16'hffff, 1'b1, 1'b1, 16'h0000},
    // Full-scale positive and negative products saturate.
    '{16'h7fff, 1'b1, 1'b1, 16'h7fff},
    '{16'h8000, 1'b1, 1'b1, 16'h8001},
    // A sum of exactly -8.0 lands on the saturation threshold.
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h8000, 1'b1, 1'b1, 16'h8001},
    // One input LSB short of the threshold goes through the series.
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h8001, 1'b1, 1'b0, 16'h0000},
    // Short vector with a mid-range sum.
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h0800, 1'b1, 1'b0, 16'h0000},
    // Full vector that ends on the position limit without a last flag.
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b0, 1'b0, 16'h0000}
  };

  localparam logic [DATA_W-1:0] DIRECTED_WEIGHTS [NUM_SYNAPSES] = '{
    16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1000, 16'hf000, 16'h7fff, 16'h8000
  };

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [DATA_W-1:0]    cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;

  // Predictor state: weights, running sum and synapse position.
  logic signed [DATA_W-1:0] weight_q [NUM_SYNAPSES];
  logic signed [ACC_W-1:0]  sum_q;
  logic [POS_W-1:0]         pos_q;
  logic [DATA_W-1:0]        next_weights [NUM_SYNAPSES];
  logic [DATA_W-1:0]        outputs_due [$];

  int errors     = 0;
  int stall_left = 0;
  bit rx_calm    = 1'b0;
  bit tx_calm    = 1'b0;

  neuron_weighted_sum_tanh u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous bound: every word ending a vector, with long stalls, several times over.
  initial begin
    #40_000_000;
    $display("tb_neuron_weighted_sum_tanh: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Mostly idle-free, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Q4.12 value: extremes, full range, or small enough to keep tanh off its rails.
  function automatic logic [DATA_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    if (pick <= 3) return DATA_W'($urandom);
    return DATA_W'($urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN);
  endfunction

  // tanh of a Q16.24 sum as Q1.15: 12-term series for exp(-a/8), squared
  // four times to get exp(-2a), then (1-e)/(1+e) with rounding.
  function automatic logic [DATA_W-1:0] tanh_q15(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] mag40;
    logic [63:0]      a, z, term, e, num, den, mag;
    longint           acc;
    mag40 = s[ACC_W-1] ? -s : s;
    a = {{(64-ACC_W){1'b0}}, mag40};
    if (a >= SAT_LEVEL) begin
      mag = 64'(MAG_MAX);
    end else begin
      z = a << 4;
      term = ONE_Q31;
      acc = longint'(ONE_Q31);
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = ((term * z) >> 31) / 64'(k);
        if (k % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q31)) acc = longint'(ONE_Q31);
      e = 64'(acc);
      repeat (4) e = (e * e + (64'd1 << 30)) >> 31;
      num = (ONE_Q31 - e) << 15;
      den = ONE_Q31 + e;
      mag = (num + den / 2) / den;
      if (mag > 64'(MAG_MAX)) mag = 64'(MAG_MAX);
    end
    return s[ACC_W-1] ? DATA_W'(-mag) : mag[DATA_W-1:0];
  endfunction

  // Adds one weighted input; on the end of a vector, yields the activation.
  task automatic accumulate_synapse(input logic [DATA_W-1:0] x, input logic last,
                                    output bit done, output logic [DATA_W-1:0] y);
    logic signed [MAC_W-1:0] prod;
    prod = weight_q[pos_q] * $signed(x);
    sum_q = sum_q + prod;
    done = last || (pos_q == POS_W'(NUM_SYNAPSES - 1));
    y = '0;
    if (done) begin
      y = tanh_q15(sum_q);
      sum_q = '0;
      pos_q = '0;
    end else begin
      pos_q = pos_q + 1'b1;
    end
  endtask

  // Writes all weights in order, then one write to an unused index that
  // must leave them untouched.
  task automatic write_weights();
    for (int i = 0; i < NUM_SYNAPSES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= next_weights[i];
      weight_q[i] = next_weights[i];
      @(posedge clk);
    end
    cfg_index <= CFG_IDX_W'(FIRST_SPARE_IDX + $urandom_range(0, 7));
    cfg_data <= DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one word after a random gap and, when it ends a vector, records the expected result.
  task automatic feed_word(input logic [DATA_W-1:0] x, input logic last,
                           input logic typed, input logic [DATA_W-1:0] result);
    int                gap;
    bit                done;
    logic [DATA_W-1:0] y;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accumulate_synapse(x, last, done, y);
    if (done) outputs_due.push_back(typed ? result : y);
  endtask

  // Waits for every outstanding result, then lets the block settle.
  task automatic wait_idle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (outputs_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", outputs_due.size()));
      outputs_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random back-pressure with occasional stall-free stretches.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // Each accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (outputs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %0d", $signed(m_axis_tdata)));
      end else begin
        if (m_axis_tdata !== outputs_due[0]) begin
          report_mismatch($sformatf("neuron_output got %0d expected %0d",
                                    $signed(m_axis_tdata), $signed(outputs_due[0])));
        end
        void'(outputs_due.pop_front());
      end
    end
  end

  // Stimulus: directed table, then random vectors under several weight settings.
  initial begin
    for (int i = 0; i < NUM_SYNAPSES; i++) weight_q[i] = '0;
    sum_q = '0;
    pos_q = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (i == RESET_ROWS) begin
        wait_idle();
        next_weights = DIRECTED_WEIGHTS;
        write_weights();
      end
      feed_word(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
    end

    // The first two settings hold every weight at one rail.
    for (int p = 0; p < WEIGHT_SETTINGS; p++) begin
      wait_idle();
      for (int i = 0; i < NUM_SYNAPSES; i++) begin
        if (p == 0) next_weights[i] = 16'h7fff;
        else if (p == 1) next_weights[i] = 16'h8000;
        else next_weights[i] = rand_word();
      end
      write_weights();
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        if (pos_q == '0) tx_calm = ($urandom_range(0, 4) == 0);
        feed_word(rand_word(), ($urandom_range(0, 3) == 0) || (n == WORDS_PER_SET - 1),
                  1'b0, '0);
      end
    end
    wait_idle();

    if (errors == 0) begin
      $display("tb_neuron_weighted_sum_tanh: PASS");
    end else begin
      $display("tb_neuron_weighted_sum_tanh: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
